// ===== design/assert_macros.svh =====
// Assertion helpers shared by the timer bank modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/ntb_pkg.sv =====
package ntb_pkg;

    // Payload widths of the item fields
    localparam int SLOT_W  = 8;
    localparam int PER_W   = 32;
    localparam int NEST_W  = 8;
    localparam int FSLOT_W = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NEST  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_FIRE = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic               in_ready;
        logic               rd_en;
        logic               wb_en;
        logic               cmd_apply;
        logic               emit;
        t_kind              kind;
        logic               level;
        logic [FSLOT_W-1:0] slot;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic               in_acc;
        logic               out_free;
        logic               is_tick;
        logic               grp_ok;
        logic               match;
        logic [FSLOT_W-1:0] nest_cnt;
    } t_dp_sts;

endpackage

// ===== design/ntb_if.sv =====
// Command channel into the timer bank
interface ntb_in_if import ntb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic              group;
    logic              level;
    logic [SLOT_W-1:0] slot;
    logic [PER_W-1:0]  period;
    logic [NEST_W-1:0] nest_count;

    modport source (output valid, cmd, group, level, slot, period, nest_count,
                    input ready);
    modport sink (input valid, cmd, group, level, slot, period, nest_count,
                  output ready);
endinterface

// Result channel out of the timer bank
interface ntb_out_if import ntb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               accepted;
    logic               fired_group;
    logic               fired_level;
    logic [FSLOT_W-1:0] fired_slot;
    logic               last;

    modport source (output valid, kind, accepted, fired_group, fired_level,
                    fired_slot, last, input ready);
    modport sink (input valid, kind, accepted, fired_group, fired_level,
                  fired_slot, last, output ready);
endinterface

// ===== design/ntb_dp.sv =====
`include "assert_macros.svh"

module ntb_dp import ntb_pkg::*; #(
    parameter int EVENTS = 8,
    parameter int GROUPS = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ntb_in_if.sink  i_in,
    ntb_out_if.source o_out,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts
);

    localparam int SW = $clog2(EVENTS);
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ND = GROUPS * 2 * EVENTS;
    localparam int AW = $clog2(ND);
    localparam int NN = GROUPS * EVENTS;
    localparam int NW = $clog2(NN);

    // Flat timer index of (group, level, slot)
    function automatic logic [AW-1:0] f_taddr(logic [GW-1:0] g, logic lvl,
                                              logic [SW-1:0] s);
        return AW'((32'(g) * 2 + 32'(lvl)) * EVENTS + 32'(s));
    endfunction

    // Captured item
    t_cmd              r_cmd;
    logic              r_group;
    logic              r_level;
    logic [SLOT_W-1:0] r_slot;
    logic [PER_W-1:0]  r_period;
    logic [NEST_W-1:0] r_nest;

    // Timer store: {period, count} per timer, valid bits stand for the reset value
    logic [2*PER_W-1:0] r_mem [ND];
    logic [ND-1:0]      r_vld;
    logic [2*PER_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;

    // Nest counts per main timer
    logic [SW-1:0] r_nc [NN];

    // Result register
    logic               r_ov;
    t_kind              r_o_kind;
    logic               r_o_acc;
    logic               r_o_grp;
    logic               r_o_lvl;
    logic [FSLOT_W-1:0] r_o_slot;
    logic               r_o_last;

    logic               w_in_acc;
    logic               w_grp_ok;
    logic               w_cmd_ok;
    logic [GW-1:0]      w_g;
    logic [AW-1:0]      w_walk_addr;
    logic [AW-1:0]      w_cmd_addr;
    logic [NW-1:0]      w_walk_nidx;
    logic [NW-1:0]      w_cmd_nidx;
    logic [PER_W-1:0]   w_per;
    logic [PER_W-1:0]   w_cnt;
    logic [PER_W-1:0]   w_inc;
    logic               w_match;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [2*PER_W-1:0] w_wr_data;
    logic               w_out_free;
    logic               w_fire;

    assign w_in_acc   = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;

    // Capture the item on accept
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= t_cmd'(i_in.cmd);
            r_group  <= i_in.group;
            r_level  <= i_in.level;
            r_slot   <= i_in.slot;
            r_period <= i_in.period;
            r_nest   <= i_in.nest_count;
        end
    end

    // Check the item's indexes
    assign w_g      = GW'(r_group);
    assign w_grp_ok = {31'b0, r_group} < 32'(GROUPS);
    assign w_cmd_ok = w_grp_ok && ({24'b0, r_slot} < 32'(EVENTS)) &&
                      ((r_cmd != CMD_NEST) || ({24'b0, r_nest} <= 32'(EVENTS - 1)));

    assign w_walk_addr = f_taddr(w_g, i_cmd.level, i_cmd.slot[SW-1:0]);
    assign w_cmd_addr  = f_taddr(w_g, r_level, r_slot[SW-1:0]);
    assign w_walk_nidx = NW'(32'(w_g) * EVENTS + 32'(i_cmd.slot[SW-1:0]));
    assign w_cmd_nidx  = NW'(32'(w_g) * EVENTS + 32'(r_slot[SW-1:0]));

    // Advance the timer just read
    assign w_per   = r_rd_vld ? r_rd_data[2*PER_W-1:PER_W] : '0;
    assign w_cnt   = r_rd_vld ? r_rd_data[PER_W-1:0] : '0;
    assign w_inc   = ((w_cnt == '1) ? '0 : w_cnt) + PER_W'(1);
    assign w_match = (w_inc == w_per);

    // Select the store write: walk write-back or start/stop
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_rd_addr;
        w_wr_data = {w_per, (w_match ? {PER_W{1'b0}} : w_inc)};
        if (i_cmd.wb_en) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.cmd_apply && w_cmd_ok) begin
            w_wr_addr = w_cmd_addr;
            unique case (r_cmd)
                CMD_START: begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {r_period, {PER_W{1'b0}}};
                end
                CMD_STOP: begin
                    w_wr_en   = 1'b1;
                    w_wr_data = '0;
                end
                CMD_TICK, CMD_NEST: begin
                    w_wr_en = 1'b0;
                end
            endcase
        end
    end

    // Timer store ports
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_walk_addr];
            r_rd_addr <= w_walk_addr;
        end
    end

    // Valid bits, read-side valid and nest counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            for (int k = 0; k < NN; k++) begin
                r_nc[k] <= '0;
            end
        end else begin
            if (w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_vld[w_walk_addr];
            end
            if (i_cmd.cmd_apply && w_cmd_ok && (r_cmd == CMD_NEST)) begin
                r_nc[w_cmd_nidx] <= r_nest[SW-1:0];
            end
        end
    end

    // Result register
    assign w_out_free = !r_ov || o_out.ready;
    assign w_fire     = (i_cmd.kind == KIND_FIRE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind <= i_cmd.kind;
            r_o_acc  <= (i_cmd.kind == KIND_ACK) && w_cmd_ok;
            r_o_grp  <= w_fire ? r_group : 1'b0;
            r_o_lvl  <= w_fire ? i_cmd.level : 1'b0;
            r_o_slot <= w_fire ? i_cmd.slot : '0;
            r_o_last <= !w_fire;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_o_kind;
    assign o_out.accepted    = r_o_acc;
    assign o_out.fired_group = r_o_grp;
    assign o_out.fired_level = r_o_lvl;
    assign o_out.fired_slot  = r_o_slot;
    assign o_out.last        = r_o_last;

    // Status back to the controller
    assign o_sts.in_acc   = w_in_acc;
    assign o_sts.out_free = w_out_free;
    assign o_sts.is_tick  = (r_cmd == CMD_TICK);
    assign o_sts.grp_ok   = w_grp_ok;
    assign o_sts.match    = w_match;
    assign o_sts.nest_cnt = FSLOT_W'(r_nc[w_walk_nidx]);

    `ASSERT_NEVER(a_rd_wr_clash, i_clk, i_rst_n, i_cmd.rd_en && w_wr_en,
                  "timer store read and written in one cycle")

endmodule

// ===== design/ntb_ctrl.sv =====
`include "assert_macros.svh"

module ntb_ctrl import ntb_pkg::*; #(
    parameter int EVENTS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int SW = $clog2(EVENTS);
    localparam logic [SW-1:0] LAST = SW'(EVENTS - 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CMD  = 7'b0000010,
        ST_MRD  = 7'b0000100,
        ST_MEV  = 7'b0001000,
        ST_NRD  = 7'b0010000,
        ST_NEV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [SW-1:0] r_i, n_i;
    logic [SW-1:0] r_j, n_j;
    logic [SW-1:0] r_cnt, n_cnt;
    logic          w_main_last;
    logic          w_nest_last;
    t_state        w_after_main;

    assign w_main_last  = (r_i == LAST);
    assign w_nest_last  = (r_j == r_cnt - SW'(1));
    assign w_after_main = w_main_last ? ST_DONE : ST_MRD;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.kind = KIND_ACK;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_acc) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                if (i_sts.is_tick) begin
                    n_i     = '0;
                    n_state = i_sts.grp_ok ? ST_MRD : ST_DONE;
                end else if (i_sts.out_free) begin
                    o_cmd.cmd_apply = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = KIND_ACK;
                    n_state         = ST_IDLE;
                end
            end
            ST_MRD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.slot  = FSLOT_W'(r_i);
                n_state     = ST_MEV;
            end
            ST_MEV: begin
                // Write back the main timer; expand into nested timers or fire
                o_cmd.slot = FSLOT_W'(r_i);
                if (!i_sts.match) begin
                    o_cmd.wb_en = 1'b1;
                    n_i         = r_i + SW'(1);
                    n_state     = w_after_main;
                end else if (i_sts.nest_cnt != '0) begin
                    o_cmd.wb_en = 1'b1;
                    n_cnt       = i_sts.nest_cnt[SW-1:0];
                    n_j         = '0;
                    n_state     = ST_NRD;
                end else if (i_sts.out_free) begin
                    o_cmd.wb_en = 1'b1;
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = KIND_FIRE;
                    n_i         = r_i + SW'(1);
                    n_state     = w_after_main;
                end
            end
            ST_NRD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.level = 1'b1;
                o_cmd.slot  = FSLOT_W'(r_j);
                n_state     = ST_NEV;
            end
            ST_NEV: begin
                // Write back the nested timer; hold while a fire waits for room
                o_cmd.level = 1'b1;
                o_cmd.slot  = FSLOT_W'(r_j);
                if (!i_sts.match || i_sts.out_free) begin
                    o_cmd.wb_en = 1'b1;
                    o_cmd.emit  = i_sts.match;
                    o_cmd.kind  = KIND_FIRE;
                    n_j         = r_j + SW'(1);
                    if (w_nest_last) begin
                        n_i     = r_i + SW'(1);
                        n_state = w_after_main;
                    end else begin
                        n_state = ST_NRD;
                    end
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DONE;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
        end
    end

    `ASSERT_CLK(a_emit_room, i_clk, i_rst_n, o_cmd.emit |-> i_sts.out_free,
                "result issued while output register is full")
    `ASSERT_CLK(a_nest_range, i_clk, i_rst_n,
                (r_state == ST_NEV) |-> (r_cnt != '0 && r_j < r_cnt),
                "nested walk index outside nest count")
    `ASSERT_NEVER(a_wb_apply, i_clk, i_rst_n, o_cmd.wb_en && o_cmd.cmd_apply,
                  "walk write-back and command write together")

endmodule

// ===== design/nested_virtual_timer_bank.sv =====
// Channel   Dir  Handshake          Payload
// i_in      in   valid/ready        cmd, group, level, slot, period, nest_count
// o_out     out  valid/ready        kind, accepted, fired_group, fired_level,
//                                   fired_slot, last
//
// A start, stop or nest-count command is taken in ST_IDLE and acknowledged from
// ST_CMD once the result register is free. A tick walks every main timer and,
// for each expiring parent, the nested timers it advances, then issues the done
// marker; the single-port timer store takes one read, then one write-back per
// timer. A tick of an absent group skips the walk. The next item is taken no
// earlier than the cycle after the last result of the previous one is issued.
// Reset is synchronous and clears all timers at once through per-entry valid
// bits; no clearing pass.
// A full result register holds the walk until o_out takes the result.

module nested_virtual_timer_bank import ntb_pkg::*; #(
    parameter int EVENTS = 8,
    parameter int GROUPS = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ntb_in_if.sink    i_in,
    ntb_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ntb_ctrl #(
        .EVENTS (EVENTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ntb_dp #(
        .EVENTS (EVENTS),
        .GROUPS (GROUPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import ntb_pkg::*; ();

    localparam int EVENTS = 8;
    localparam int GROUPS = 2;

    // One command item as the sender presents it
    typedef struct packed {
        t_cmd               cmd;
        logic               group;
        logic               level;
        logic [SLOT_W-1:0]  slot;
        logic [PER_W-1:0]   period;
        logic [NEST_W-1:0]  nest_count;
    } t_cmd_item;

    // One result item as the block returns it
    typedef struct packed {
        t_kind              kind;
        logic               accepted;
        logic               fired_group;
        logic               fired_level;
        logic [FSLOT_W-1:0] fired_slot;
        logic               last;
    } t_timer_event;

    // Timer bank predictor plus the queue of events still owed by the block
    class t_timer_bank_scoreboard;
        bit [31:0]     tick_cnt[GROUPS][2][EVENTS];
        bit [31:0]     period_of[GROUPS][2][EVENTS];
        bit [2:0]      nest_of[GROUPS][EVENTS];
        t_timer_event  expected_events[$];
        int            mismatches;
        int            commands;
        int            ticks;
        int            checked;
        int            fires;
        int            burst;
        int            widest_burst;

        // Count one timer; report a period match and clear the count on it
        function bit bump_timer(int g, int l, int s);
            if (tick_cnt[g][l][s] == 32'hFFFF_FFFF) begin
                tick_cnt[g][l][s] = 32'd0;
            end
            tick_cnt[g][l][s] = tick_cnt[g][l][s] + 32'd1;
            if (tick_cnt[g][l][s] == period_of[g][l][s]) begin
                tick_cnt[g][l][s] = 32'd0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_event(t_kind k, bit acc, bit g, bit l, bit [2:0] s, bit lst);
            t_timer_event ev;
            ev = '{kind: k, accepted: acc, fired_group: g, fired_level: l,
                   fired_slot: s, last: lst};
            expected_events.push_back(ev);
            if (k == KIND_FIRE) begin
                burst++;
            end
        endfunction

        // Update the model for one accepted command and queue its events
        function void note_command(t_cmd_item c);
            bit ok;
            int g;
            int s;
            g = int'(c.group);
            s = int'(c.slot);
            commands++;
            if (c.cmd == CMD_TICK) begin
                ticks++;
                burst = 0;
                if (g < GROUPS) begin
                    for (int i = 0; i < EVENTS; i++) begin
                        if (!bump_timer(g, 0, i)) continue;
                        if (nest_of[g][i] != 0) begin
                            // nested timers are shared by every expiring parent
                            for (int j = 0; j < nest_of[g][i] && j < EVENTS; j++) begin
                                if (bump_timer(g, 1, j)) begin
                                    push_event(KIND_FIRE, 1'b0, 1'(g), 1'b1, 3'(j), 1'b0);
                                end
                            end
                        end else begin
                            push_event(KIND_FIRE, 1'b0, 1'(g), 1'b0, 3'(i), 1'b0);
                        end
                    end
                end
                push_event(KIND_DONE, 0, 0, 0, 0, 1);
                if (burst > widest_burst) widest_burst = burst;
            end else begin
                ok = (g < GROUPS) && (s < EVENTS);
                if (c.cmd == CMD_NEST && c.nest_count > EVENTS - 1) ok = 1'b0;
                if (ok) begin
                    case (c.cmd)
                        CMD_START: begin
                            period_of[g][c.level][s] = c.period;
                            tick_cnt[g][c.level][s]  = 32'd0;
                        end
                        CMD_STOP: begin
                            period_of[g][c.level][s] = 32'd0;
                            tick_cnt[g][c.level][s]  = 32'd0;
                        end
                        default: begin
                            nest_of[g][s] = c.nest_count[2:0];
                        end
                    endcase
                end
                push_event(KIND_ACK, ok, 0, 0, 0, 1);
            end
        endfunction

        // Compare one returned event with the oldest one owed
        function void check_event(t_timer_event got);
            t_timer_event want;
            checked++;
            if (got.kind == KIND_FIRE) fires++;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected result kind=%0d acc=%0d g=%0d l=%0d %s",
                             got.kind, got.accepted, got.fired_group, got.fired_level,
                             $sformatf("s=%0d last=%0d", got.fired_slot, got.last));
                end
                return;
            end
            want = expected_events.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d expected kind=%0d acc=%0d g=%0d l=%0d %s",
                             checked, want.kind, want.accepted, want.fired_group,
                             want.fired_level,
                             $sformatf("s=%0d last=%0d", want.fired_slot, want.last));
                    $display("       got              kind=%0d acc=%0d g=%0d l=%0d %s",
                             got.kind, got.accepted, got.fired_group, got.fired_level,
                             $sformatf("s=%0d last=%0d", got.fired_slot, got.last));
                end
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    t_timer_bank_scoreboard sb;

    ntb_in_if  in_if ();
    ntb_out_if out_if ();

    nested_virtual_timer_bank #(
        .EVENTS (EVENTS),
        .GROUPS (GROUPS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4ms;
        $display("nested_virtual_timer_bank: mismatch");
        $finish;
    end

    function automatic bit take_idle();
        return !steady && ($urandom_range(0, 99) < 14);
    endfunction

    function automatic t_cmd_item make_cmd(t_cmd c, bit g, bit l, int s,
                                           logic [PER_W-1:0] p, int nc);
        t_cmd_item it;
        it = '{cmd: c, group: g, level: l, slot: s[SLOT_W-1:0], period: p,
               nest_count: nc[NEST_W-1:0]};
        return it;
    endfunction

    // Present one command, with an optional idle gap, and hold it until taken
    task automatic send_command(t_cmd_item it);
        if (take_idle()) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while (take_idle());
        end
        in_if.valid      <= 1'b1;
        in_if.cmd        <= it.cmd;
        in_if.group      <= it.group;
        in_if.level      <= it.level;
        in_if.slot       <= it.slot;
        in_if.period     <= it.period;
        in_if.nest_count <= it.nest_count;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_command(it);
    endtask

    // Hold new commands until every owed event has come back
    task automatic drain_events();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: check taken items, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_event('{kind: t_kind'(out_if.kind), accepted: out_if.accepted,
                             fired_group: out_if.fired_group,
                             fired_level: out_if.fired_level,
                             fired_slot: out_if.fired_slot, last: out_if.last});
        end
        out_if.ready <= !take_idle();
    end

    initial begin
        t_cmd_item it;
        int        pick;
        sb = new();
        steady           = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= CMD_TICK;
        in_if.group      <= 1'b0;
        in_if.level      <= 1'b0;
        in_if.slot       <= '0;
        in_if.period     <= '0;
        in_if.nest_count <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, refusals, stopped timers, shared nesting
        send_command(make_cmd(CMD_TICK,  0, 0, 0,   32'd0, 0));
        send_command(make_cmd(CMD_TICK,  1, 1, 255, 32'hFFFF_FFFF, 255));
        send_command(make_cmd(CMD_START, 0, 0, 0,   32'd1, 0));
        send_command(make_cmd(CMD_TICK,  0, 0, 0,   32'd0, 0));
        send_command(make_cmd(CMD_START, 0, 0, 1,   32'd0, 0));
        send_command(make_cmd(CMD_STOP,  0, 0, 0,   32'd0, 0));
        send_command(make_cmd(CMD_START, 1, 1, 7,   32'hFFFF_FFFF, 0));
        send_command(make_cmd(CMD_START, 1, 0, 8,   32'd5, 0));
        send_command(make_cmd(CMD_START, 0, 1, 255, 32'hFFFF_FFFF, 0));
        send_command(make_cmd(CMD_STOP,  1, 1, 7,   32'd0, 0));
        send_command(make_cmd(CMD_STOP,  0, 0, 128, 32'd0, 0));
        send_command(make_cmd(CMD_NEST,  1, 1, 0,   32'd0, 7));
        send_command(make_cmd(CMD_NEST,  1, 0, 7,   32'd0, 8));
        send_command(make_cmd(CMD_NEST,  0, 0, 255, 32'd0, 255));
        send_command(make_cmd(CMD_NEST,  0, 0, 3,   32'd0, 0));
        send_command(make_cmd(CMD_START, 1, 1, 0,   32'd2, 0));
        send_command(make_cmd(CMD_START, 1, 1, 1,   32'd1, 0));
        send_command(make_cmd(CMD_START, 1, 0, 0,   32'd1, 0));
        repeat (3) send_command(make_cmd(CMD_TICK, 1, 0, 0, 32'd0, 0));
        send_command(make_cmd(CMD_NEST,  1, 0, 1,   32'd0, 2));
        send_command(make_cmd(CMD_START, 1, 0, 1,   32'd1, 0));
        send_command(make_cmd(CMD_TICK,  1, 0, 0,   32'd0, 0));
        drain_events();

        // Worst case: every main timer expires and drives seven nested ones
        for (int j = 0; j < EVENTS - 1; j++) begin
            send_command(make_cmd(CMD_START, 0, 1, j, 32'd1, 0));
        end
        for (int i = 0; i < EVENTS; i++) begin
            send_command(make_cmd(CMD_START, 0, 0, i, 32'd1, 0));
            send_command(make_cmd(CMD_NEST,  0, 0, i, 32'd0, EVENTS - 1));
        end
        repeat (2) send_command(make_cmd(CMD_TICK, 0, 0, 0, 32'd0, 0));
        // stop the mains again; their nest counts stay behind
        for (int i = 0; i < EVENTS; i++) begin
            send_command(make_cmd(CMD_STOP, 0, 0, i, 32'd0, 0));
        end
        drain_events();

        // Random: mostly sensible commands with short periods, some raw noise
        for (int n = 0; n < 320; n++) begin
            steady = (n >= 100 && n < 170);
            if (n == 200) drain_events();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                it = make_cmd(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 255), $urandom, $urandom_range(0, 255));
            end else if (pick < 70) begin
                it = make_cmd(CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, EVENTS - 1),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6), 0);
            end else if (pick < 78) begin
                it = make_cmd(CMD_NEST, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, EVENTS - 1), 32'd0,
                              $urandom_range(0, EVENTS - 1));
            end else if (pick < 83) begin
                it = make_cmd(CMD_STOP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, EVENTS - 1), 32'd0, 0);
            end else begin
                it = make_cmd(t_cmd'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom,
                              $urandom_range(0, 255));
            end
            send_command(it);
        end
        steady = 1'b0;

        // Wrap up: let the block finish, then allow for stray extra results
        drain_events();
        repeat (200) @(posedge i_clk);

        $display("Sent %0d commands (%0d ticks); checked %0d results with %0d timer fires.",
                 sb.commands, sb.ticks, sb.checked, sb.fires);
        $display("Largest single tick produced %0d fires; %0d mismatches.",
                 sb.widest_burst, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("nested_virtual_timer_bank: match");
        end else begin
            $display("nested_virtual_timer_bank: mismatch");
        end
        $finish;
    end

endmodule
